// File: src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the rotation-matrix-to-quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Fixed-point format of all matrix elements and quaternion parts.
    localparam int FRAC_BITS = 14;
    localparam int ELEM_W    = 16;
    localparam int NUM_W     = ELEM_W + 1;
    localparam int ARG_W     = 17;

    // Queue between the classifier and the arithmetic pipeline.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Pivot codes double as lane numbers: w, x, y, z.
    typedef enum logic [1:0] {
        PIV_W = 2'd0,
        PIV_X = 2'd1,
        PIV_Y = 2'd2,
        PIV_Z = 2'd3
    } piv_t;

    // Classified item as it leaves the front end.
    typedef struct packed {
        piv_t                        piv;
        logic [ARG_W-1:0]            arg;
        logic [3:0][NUM_W-1:0]       num;
    } front_t;

    // Arithmetic pipeline widths.
    localparam int SQ_W    = 48;
    localparam int DIV_W   = 40;
    localparam int Q1_W    = 23;
    localparam int ROOT1_W = 16;
    localparam int MAG_W   = 24;
    localparam int PAIR_W  = 47;

    // Step counts of the two roots and the two divisions.
    localparam int SQ1_N  = 16;
    localparam int DIV1_N = 23;
    localparam int SQ2_N  = 24;
    localparam int DIV2_N = 15;

    // Stage map of the back-end pipeline.
    localparam int ST_LOAD  = 0;
    localparam int ST_SQ1   = ST_LOAD + 1;
    localparam int ST_POST1 = ST_SQ1 + SQ1_N;
    localparam int ST_DIV1  = ST_POST1 + 1;
    localparam int ST_CSEL  = ST_DIV1 + DIV1_N;
    localparam int ST_SQR   = ST_CSEL + 1;
    localparam int ST_PAIR  = ST_SQR + 1;
    localparam int ST_SUM   = ST_PAIR + 1;
    localparam int ST_SQ2   = ST_SUM + 1;
    localparam int ST_POST2 = ST_SQ2 + SQ2_N;
    localparam int ST_DIV2  = ST_POST2 + 1;
    localparam int ST_OUT   = ST_DIV2 + DIV2_N;
    localparam int N_STAGES = ST_OUT + 1;

    // Payload carried by every pipeline stage.
    typedef struct packed {
        piv_t                        piv;
        logic                        degen;
        logic [SQ_W-1:0]             sq_v;
        logic [SQ_W-1:0]             sq_r;
        logic [ROOT1_W-1:0]          s;
        logic [MAG_W-1:0]            mag;
        logic [3:0]                  neg;
        logic [3:0][DIV_W-1:0]       rem;
        logic [3:0][Q1_W-1:0]        q;
        logic [3:0][Q1_W-1:0]        cm;
        logic [3:0][PAIR_W-1:0]      sq4;
        logic [3:0][ELEM_W-1:0]      res;
    } work_t;

endpackage

// File: src/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Accepts matrices, picks the pivot and forms the root argument and the
// numerators of the three other quaternion parts.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [9*rmq_pkg::ELEM_W-1:0]  s_tdata,
    output logic                          push_valid,
    input  logic                          push_ready,
    output rmq_pkg::front_t               push_data
);
    import rmq_pkg::*;

    logic signed [NUM_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [NUM_W:0]   tr;
    logic signed [NUM_W+1:0] arg_s;
    front_t                  cls;
    logic                    valid_reg, valid_next;
    front_t                  data_reg;

    // Sign-extended elements, row by row.
    assign a00 = NUM_W'($signed(s_tdata[0*ELEM_W +: ELEM_W]));
    assign a01 = NUM_W'($signed(s_tdata[1*ELEM_W +: ELEM_W]));
    assign a02 = NUM_W'($signed(s_tdata[2*ELEM_W +: ELEM_W]));
    assign a10 = NUM_W'($signed(s_tdata[3*ELEM_W +: ELEM_W]));
    assign a11 = NUM_W'($signed(s_tdata[4*ELEM_W +: ELEM_W]));
    assign a12 = NUM_W'($signed(s_tdata[5*ELEM_W +: ELEM_W]));
    assign a20 = NUM_W'($signed(s_tdata[6*ELEM_W +: ELEM_W]));
    assign a21 = NUM_W'($signed(s_tdata[7*ELEM_W +: ELEM_W]));
    assign a22 = NUM_W'($signed(s_tdata[8*ELEM_W +: ELEM_W]));

    assign tr = (NUM_W+1)'(a00) + (NUM_W+1)'(a11) + (NUM_W+1)'(a22);

    // Pivot selection; ties on the diagonal fall through to y, then z.
    always_comb begin
        cls.num = '0;
        if (tr > 0) begin
            cls.piv    = PIV_W;
            arg_s      = (NUM_W+2)'(1 <<< FRAC_BITS) + (NUM_W+2)'(tr);
            cls.num[1] = a21 - a12;
            cls.num[2] = a02 - a20;
            cls.num[3] = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            cls.piv    = PIV_X;
            arg_s      = (NUM_W+2)'(1 <<< FRAC_BITS) + (NUM_W+2)'(a00)
                         - (NUM_W+2)'(a11) - (NUM_W+2)'(a22);
            cls.num[0] = a21 - a12;
            cls.num[2] = a01 + a10;
            cls.num[3] = a02 + a20;
        end else if (a11 > a22) begin
            cls.piv    = PIV_Y;
            arg_s      = (NUM_W+2)'(1 <<< FRAC_BITS) + (NUM_W+2)'(a11)
                         - (NUM_W+2)'(a00) - (NUM_W+2)'(a22);
            cls.num[0] = a02 - a20;
            cls.num[1] = a01 + a10;
            cls.num[3] = a12 + a21;
        end else begin
            cls.piv    = PIV_Z;
            arg_s      = (NUM_W+2)'(1 <<< FRAC_BITS) + (NUM_W+2)'(a22)
                         - (NUM_W+2)'(a00) - (NUM_W+2)'(a11);
            cls.num[0] = a10 - a01;
            cls.num[1] = a02 + a20;
            cls.num[2] = a12 + a21;
        end
        // A negative root argument is clamped to zero.
        cls.arg = arg_s[NUM_W+1] ? '0 : arg_s[ARG_W-1:0];
    end

    // One register stage that hands items to the queue.
    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= cls;
        end
    end

endmodule

// File: src/rmq_fifo.sv
// ----------------------------------------------------------------------------
// rmq_fifo
// Short queue of classified items between the front end and the pipeline.
// ----------------------------------------------------------------------------
module rmq_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  rmq_pkg::front_t  push_data,
    output logic             head_valid,
    input  logic             pop,
    output rmq_pkg::front_t  head_data
);
    import rmq_pkg::*;

    front_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    // Space is judged on the stored count only, so ready has no path from pop.
    assign push_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Arithmetic pipeline: root of the pivot argument, four divisions, sum of
// squares, root of the magnitude, four normalizing divisions.
// ----------------------------------------------------------------------------
module rmq_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  rmq_pkg::front_t               head_data,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [4*rmq_pkg::ELEM_W-1:0]  m_tdata,
    output logic                          m_tuser
);
    import rmq_pkg::*;

    logic  ce;
    logic  [N_STAGES-1:0] valid_reg;
    work_t work_reg [N_STAGES];

    // Turns a queue entry into the first stage's payload.
    function automatic work_t load(input front_t f);
        work_t            o;
        logic [NUM_W-1:0] m;
        o      = '0;
        o.piv  = f.piv;
        o.sq_v = {{(SQ_W-ARG_W-FRAC_BITS){1'b0}}, f.arg, {FRAC_BITS{1'b0}}};
        for (int l = 0; l < 4; l++) begin
            o.neg[l] = f.num[l][NUM_W-1];
            m        = o.neg[l] ? (NUM_W)'(-f.num[l]) : f.num[l];
            o.rem[l] = {{(DIV_W-NUM_W-FRAC_BITS){1'b0}}, m, {FRAC_BITS{1'b0}}};
        end
        return o;
    endfunction

    // One step of a digit-by-digit integer square root.
    function automatic work_t root_step(input work_t w, input int sh);
        work_t           o;
        logic [SQ_W-1:0] b, t;
        o = w;
        b = SQ_W'(1) << sh;
        t = w.sq_r + b;
        if (w.sq_v >= t) begin
            o.sq_v = w.sq_v - t;
            o.sq_r = (w.sq_r >> 1) + b;
        end else begin
            o.sq_r = w.sq_r >> 1;
        end
        return o;
    endfunction

    // One quotient bit of four parallel restoring divisions.
    function automatic work_t div_step(input work_t w, input logic [DIV_W-1:0] d,
                                       input int bit_idx);
        work_t            o;
        logic [DIV_W-1:0] dd;
        o  = w;
        dd = d << bit_idx;
        for (int l = 0; l < 4; l++) begin
            if (w.rem[l] >= dd) begin
                o.rem[l]        = w.rem[l] - dd;
                o.q[l][bit_idx] = 1'b1;
            end
        end
        return o;
    endfunction

    // Work done by stage idx; idx is constant for each stage.
    function automatic work_t step(input int idx, input work_t w);
        work_t                o;
        logic [2*Q1_W-1:0]    prod;
        logic [ELEM_W-1:0]    qv;
        o = w;
        if (idx >= ST_SQ1 && idx < ST_POST1) begin
            o = root_step(w, 2 * (SQ1_N - 1 - (idx - ST_SQ1)));
        end else if (idx == ST_POST1) begin
            // Root of the argument; the divisor k4 is twice this.
            o.s     = w.sq_r[ROOT1_W-1:0];
            o.degen = (w.sq_r[ROOT1_W-1:0] == '0);
        end else if (idx >= ST_DIV1 && idx < ST_CSEL) begin
            o = div_step(w, {{(DIV_W-ROOT1_W-1){1'b0}}, w.s, 1'b0},
                         DIV1_N - 1 - (idx - ST_DIV1));
        end else if (idx == ST_CSEL) begin
            // The pivot part is k4/4, always positive.
            for (int l = 0; l < 4; l++) begin
                if (w.piv == piv_t'(l)) begin
                    o.cm[l]  = Q1_W'(w.s >> 1);
                    o.neg[l] = 1'b0;
                end else begin
                    o.cm[l] = w.q[l];
                end
            end
        end else if (idx == ST_SQR) begin
            for (int l = 0; l < 4; l++) begin
                prod     = {{Q1_W{1'b0}}, w.cm[l]} * {{Q1_W{1'b0}}, w.cm[l]};
                o.sq4[l] = {1'b0, prod};
            end
        end else if (idx == ST_PAIR) begin
            o.sq4[0] = w.sq4[0] + w.sq4[1];
            o.sq4[1] = w.sq4[2] + w.sq4[3];
        end else if (idx == ST_SUM) begin
            o.sq_v = {1'b0, w.sq4[0]} + {1'b0, w.sq4[1]};
            o.sq_r = '0;
        end else if (idx >= ST_SQ2 && idx < ST_POST2) begin
            o = root_step(w, 2 * (SQ2_N - 1 - (idx - ST_SQ2)));
        end else if (idx == ST_POST2) begin
            // Magnitude; set up the normalizing divisions.
            o.mag   = w.sq_r[MAG_W-1:0];
            o.degen = w.degen || (w.sq_r[MAG_W-1:0] == '0);
            for (int l = 0; l < 4; l++) begin
                o.rem[l] = {{(DIV_W-Q1_W-FRAC_BITS){1'b0}}, w.cm[l],
                            {FRAC_BITS{1'b0}}};
                o.q[l]   = '0;
            end
        end else if (idx >= ST_DIV2 && idx < ST_OUT) begin
            o = div_step(w, {{(DIV_W-MAG_W){1'b0}}, w.mag},
                         DIV2_N - 1 - (idx - ST_DIV2));
        end else if (idx == ST_OUT) begin
            // Each quotient is at most ONE since no part exceeds the
            // magnitude, so the signed result always fits.
            for (int l = 0; l < 4; l++) begin
                qv       = {1'b0, w.q[l][ELEM_W-2:0]};
                o.res[l] = w.degen ? '0 : (w.neg[l] ? -qv : qv);
            end
        end
        return o;
    endfunction

    // The whole pipeline advances unless the result register is held.
    assign ce  = !valid_reg[N_STAGES-1] || m_tready;
    assign pop = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[N_STAGES-2:0], head_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            work_reg[0] <= load(head_data);
        end
    end

    for (genvar g = 1; g < N_STAGES; g++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (ce) begin
                work_reg[g] <= step(g, work_reg[g-1]);
            end
        end
    end

    // Result transfer comes straight from the last stage.
    assign m_tvalid = valid_reg[N_STAGES-1];
    assign m_tdata  = {work_reg[N_STAGES-1].res[3], work_reg[N_STAGES-1].res[2],
                       work_reg[N_STAGES-1].res[1], work_reg[N_STAGES-1].res[0]};
    assign m_tuser  = work_reg[N_STAGES-1].degen;

endmodule

// File: src/rotation_matrix_to_quaternion.sv
// Throughput: one matrix per cycle; the pipeline holds only while m_tready is low.
// The depth is set by the bit-per-stage square roots and restoring dividers.
// Reset: aresetn is synchronous and active low; it empties the queue and pipeline.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation in Q2.14 to a normalized unit quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // e00, e01, e02, e10, e11, e12, e20, e21, e22 (16 bits each, lowest first)
    input  logic [9*rmq_pkg::ELEM_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // quat_w, quat_x, quat_y, quat_z (16 bits each, lowest first)
    output logic [4*rmq_pkg::ELEM_W-1:0]  m_tdata,
    // degenerate
    output logic                          m_tuser
);
    import rmq_pkg::*;

    logic   push_valid, push_ready, head_valid, pop;
    front_t push_data, head_data;

    rmq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rmq_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (pop),
        .head_data  (head_data)
    );

    rmq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// File: verif/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Watches both streams of the rotation-to-quaternion block, computes the
// expected quaternion for every accepted matrix and compares in order.
// ----------------------------------------------------------------------------
module rmq_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // e00, e01, e02, e10, e11, e12, e20, e21, e22 (16 bits each, lowest first)
    input  logic [9*rmq_pkg::ELEM_W-1:0]  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // quat_w, quat_x, quat_y, quat_z (16 bits each, lowest first)
    input  logic [4*rmq_pkg::ELEM_W-1:0]  m_tdata,
    // degenerate
    input  logic                          m_tuser,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count,
    output int                            degen_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    typedef struct {
        logic [4*ELEM_W-1:0] quat;
        logic                degen;
    } quat_exp_t;

    quat_exp_t quat_queue[$];

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Shifted division truncated toward zero.
    function automatic longint scaled_div(longint n, longint unsigned d);
        longint unsigned a;
        longint unsigned q;
        a = (n < 0) ? longint'(-n) : n;
        q = (a << FRAC_BITS) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic quat_exp_t predict_quat(logic [9*ELEM_W-1:0] m);
        longint e[9];
        longint one, tr, arg, lim;
        longint num[4];
        longint part[4];
        longint unsigned s, k4, mag2, mag, u;
        piv_t piv;
        quat_exp_t r;
        for (int i = 0; i < 9; i++) e[i] = longint'($signed(m[i*ELEM_W +: ELEM_W]));
        one = longint'(1) << FRAC_BITS;
        tr  = e[0] + e[4] + e[8];
        r.quat  = '0;
        r.degen = 1'b1;
        if (tr > 0) begin
            piv = PIV_W; arg = one + tr;
            num[1] = e[7] - e[5]; num[2] = e[2] - e[6]; num[3] = e[3] - e[1];
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            piv = PIV_X; arg = one + e[0] - e[4] - e[8];
            num[0] = e[7] - e[5]; num[2] = e[1] + e[3]; num[3] = e[2] + e[6];
        end else if (e[4] > e[8]) begin
            piv = PIV_Y; arg = one + e[4] - e[0] - e[8];
            num[0] = e[2] - e[6]; num[1] = e[1] + e[3]; num[3] = e[5] + e[7];
        end else begin
            piv = PIV_Z; arg = one + e[8] - e[0] - e[4];
            num[0] = e[3] - e[1]; num[1] = e[2] + e[6]; num[2] = e[5] + e[7];
        end
        num[piv] = 0;
        if (arg < 0) arg = 0;
        s  = int_sqrt(longint'(arg) << FRAC_BITS);
        k4 = s << 1;
        if (k4 == 0) return r;
        mag2 = 0;
        for (int i = 0; i < 4; i++) begin
            part[i] = (i == piv) ? longint'(s >> 1) : scaled_div(num[i], k4);
            u = (part[i] < 0) ? longint'(-part[i]) : part[i];
            mag2 += u * u;
        end
        mag = int_sqrt(mag2);
        if (mag == 0) return r;
        for (int i = 0; i < 4; i++) begin
            lim = scaled_div(part[i], mag);
            if (lim > 32767) lim = 32767;
            if (lim < -32768) lim = -32768;
            r.quat[i*ELEM_W +: ELEM_W] = lim[ELEM_W-1:0];
        end
        r.degen = 1'b0;
        return r;
    endfunction

    assign pending = quat_queue.size();

    // Predict on every input transfer and check every result transfer.
    always @(posedge aclk) begin
        quat_exp_t want;
        if (!aresetn) begin
            fail_count   <= 0;
            result_count <= 0;
            degen_count  <= 0;
        end else begin
            if (s_tvalid && s_tready) quat_queue.push_back(predict_quat(s_tdata));
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (m_tuser) degen_count <= degen_count + 1;
                if (quat_queue.size() == 0) begin
                    $display("%0t: unexpected result quat=%h degenerate=%b",
                             $time, m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    want = quat_queue.pop_front();
                    if (want.quat !== m_tdata || want.degen !== m_tuser) begin
                        $display("%0t: mismatch expected quat=%h degenerate=%b, got quat=%h degenerate=%b",
                                 $time, want.quat, want.degen, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random matrices into the rotation-to-quaternion block
// with random gaps and back pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 120;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [9*ELEM_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [4*ELEM_W-1:0]   m_tdata;
    logic                  m_tuser;
    int                    fail_count, pending, result_count, degen_count;
    int                    sent_count = 0;
    bit                    sending = 1'b1;

    always #5 aclk = ~aclk;

    rotation_matrix_to_quaternion dut (.*);

    rmq_checker checker_i (.*);

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
            3: return 16'(int'($urandom_range(0, 800)) - 400);
            default: return 16'($urandom());
        endcase
    endfunction

    // A proper rotation about one axis at a whole-degree angle, at times with small noise added.
    function automatic logic [9*ELEM_W-1:0] rand_rotation();
        logic [ELEM_W-1:0] c, s, ns, o, z;
        logic [9*ELEM_W-1:0] m;
        real ang;
        ang = ($urandom_range(0, 359) * 3.14159265) / 180.0;
        c  = 16'($rtoi($cos(ang) * 16384.0));
        s  = 16'($rtoi($sin(ang) * 16384.0));
        ns = -s; o = 16'h4000; z = '0;
        case ($urandom_range(0, 2))
            0: m = {c, s, z, ns, c, z, z, z, o};
            1: m = {c, z, ns, z, o, z, s, z, c};
            default: m = {o, z, z, z, c, s, z, ns, c};
        endcase
        if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < 9; i++)
                m[i*ELEM_W +: ELEM_W] += 16'(int'($urandom_range(0, 16)) - 8);
        return m;
    endfunction

    task automatic send_matrix(logic [9*ELEM_W-1:0] m);
        int g;
        g = gap_len();
        repeat (g) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
        @(negedge aclk);
    endtask

    // Diagonal matrix: e00, e11 and e22 set, the six off-diagonal elements zero.
    function automatic logic [9*ELEM_W-1:0] diag(int a, int b, int c);
        return {16'(c), 48'd0, 16'(b), 48'd0, 16'(a)};
    endfunction

    // Receiver back pressure.
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("Timeout: %0d sent, %0d pending", sent_count, pending);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [9*ELEM_W-1:0] m;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: identity, each pivot, ties, zero, extremes.
        send_matrix(diag(16384, 16384, 16384));
        send_matrix(diag(16384, -16384, -16384));
        send_matrix(diag(-16384, 16384, -16384));
        send_matrix(diag(-16384, -16384, 16384));
        send_matrix(diag(-100, -100, -100));
        send_matrix(diag(0, 0, 0));
        send_matrix(diag(-16384, -16384, -16384));
        send_matrix(diag(-32768, -32768, -32768));
        send_matrix(diag(32767, 32767, 32767));
        send_matrix(diag(-32768, 32767, -32768));
        send_matrix(diag(-5, -5, -10));
        send_matrix(diag(-20000, -20000, -20000));
        send_matrix('0);
        send_matrix({9{16'h7fff}});
        send_matrix({9{16'h8000}});
        send_matrix({9{16'hffff}});
        send_matrix({16'h4000, 16'h8000, 16'h7fff, 16'h7fff, 16'hc000,
                     16'h8000, 16'h8000, 16'h7fff, 16'hc000});
        send_matrix({16'hc000, 16'h7fff, 16'h8000, 16'h8000, 16'hc000,
                     16'h7fff, 16'h7fff, 16'h8000, 16'h4000});
        send_matrix({16'h0000, 16'h5555, 16'haaaa, 16'haaaa, 16'h0000,
                     16'h5555, 16'h5555, 16'haaaa, 16'h0000});

        // Pause until the pipeline has drained.
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);

        // Random: mostly real rotations, the rest arbitrary elements.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 60) begin
                m = rand_rotation();
            end else begin
                for (int i = 0; i < 9; i++) m[i*ELEM_W +: ELEM_W] = rand_elem();
            end
            send_matrix(m);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d matrices with both streams stalling at random;", sent_count);
        $display("checked %0d quaternions, %0d of them degenerate.", result_count, degen_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
src/rmq_pkg.sv
src/rmq_front.sv
src/rmq_fifo.sv
src/rmq_back.sv
src/rotation_matrix_to_quaternion.sv
verif/rmq_checker.sv
verif/tb_top.sv
